FILE: rtl/dcpm_pkg.sv
// Shared types, widths and constants of the DC-blocked power meter.
// Used by the channel interfaces, the multiply unit, the sequencer and the top level.
package dcpm_pkg;

  // Field widths of the channels
  localparam int CH_W      = 2;
  localparam int SAMPLE_W  = 12;
  localparam int VALUE_W   = 14;
  localparam int SUM_W     = 48;
  localparam int COUNT_W   = 32;
  localparam int SCALE_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Defaults of the top-level parameters
  localparam int DEF_CHANNELS = 4;
  localparam int DEF_DC_SHIFT = 8;

  // Gain has sixteen fraction bits
  localparam int GAIN_SHIFT = 16;

  localparam int MIDSCALE = 2048;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(100);

  // Datapath widths
  localparam int DIFF_W  = SAMPLE_W + 1;
  localparam int MUL_A_W = VALUE_W;
  localparam int MUL_B_W = SCALE_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SQ_W    = 2 * VALUE_W - 1;

  localparam logic signed [PROD_W-1:0] VAL_MAX = PROD_W'(8191);
  localparam logic signed [PROD_W-1:0] VAL_MIN = -PROD_W'(8192);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_SCALE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCALE = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_SCALE,
    S_SQUARE,
    S_ACC
  } state_e;

  typedef enum logic {
    MUL_SCALE,
    MUL_SQUARE
  } mul_op_e;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    diff_en;
    logic    mul_en;
    mul_op_e mul_op;
    logic    val_en;
    logic    commit;
  } ctrl_t;

endpackage

FILE: rtl/dcpm_intf.sv
// Valid/ready channel interfaces of the DC-blocked power meter: sample in, result out
// and configuration write. Depends on dcpm_pkg.
interface dcpm_in_if;
  import dcpm_pkg::*;
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     channel;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

interface dcpm_out_if;
  import dcpm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CH_W-1:0]           channel_out;
  logic signed [VALUE_W-1:0] value;
  logic [SUM_W-1:0]          sum_squares;
  logic [COUNT_W-1:0]        sample_count;

  modport source (output valid, output channel_out, output value, output sum_squares,
                  output sample_count, input ready);
  modport sink (input valid, input channel_out, input value, input sum_squares,
                input sample_count, output ready);
endinterface

interface dcpm_cfg_if;
  import dcpm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SCALE_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/dcpm_mul.sv
// Shared signed multiplier with operand select and registered product.
// Serves both the gain scaling and the squaring step. Depends on dcpm_pkg.
module dcpm_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  dcpm_pkg::mul_op_e                   op_i,
  input  logic signed [dcpm_pkg::DIFF_W-1:0]  diff_i,
  input  logic [dcpm_pkg::SCALE_W-1:0]        gain_i,
  input  logic signed [dcpm_pkg::VALUE_W-1:0] val_i,
  output logic signed [dcpm_pkg::PROD_W-1:0]  prod_o
);
  import dcpm_pkg::*;

  logic signed [MUL_A_W-1:0] a;
  logic signed [MUL_B_W-1:0] b;
  logic signed [PROD_W-1:0]  prod_d, prod_q;

  always_comb begin
    unique case (op_i)
      MUL_SCALE: begin
        a = MUL_A_W'(diff_i);
        b = $signed({1'b0, gain_i});
      end
      MUL_SQUARE: begin
        a = val_i;
        b = MUL_B_W'(val_i);
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
    prod_d = PROD_W'(a) * PROD_W'(b);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/dcpm_seq.sv
// Step sequencer of the power meter: offset update, scale, square, accumulate.
// Drives the datapath control struct. Depends on dcpm_pkg.
module dcpm_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            ch_ok_i,
  input  logic            out_free_i,
  output dcpm_pkg::ctrl_t ctrl_o
);
  import dcpm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.mul_op = MUL_SCALE;
    unique case (state_q)
      S_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        ctrl_o.capture  = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        // drop a sample of a channel that is not fitted
        if (ch_ok_i) begin
          ctrl_o.diff_en = 1'b1;
          state_d        = S_SCALE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCALE: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = MUL_SCALE;
        state_d       = S_SQUARE;
      end
      S_SQUARE: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = MUL_SQUARE;
        ctrl_o.val_en = 1'b1;
        state_d       = S_ACC;
      end
      S_ACC: begin
        // hold until the result register is free, then take the next sample
        if (out_free_i) begin
          ctrl_o.commit   = 1'b1;
          ctrl_o.in_ready = 1'b1;
          ctrl_o.capture  = in_valid_i;
          state_d         = in_valid_i ? S_DIFF : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/dc_blocked_power_meter.sv
// Top level of the DC-blocked power meter: channel state, configuration and result register.
// Depends on dcpm_pkg, dcpm_intf, dcpm_mul and dcpm_seq.
//
//  port   | modport | payload                                         | role
//  -------+---------+-------------------------------------------------+----------------------
//  cfg_i  | sink    | index, data                                     | gain register write
//  in_i   | sink    | channel, sample                                 | converter samples in
//  res_o  | source  | channel_out, value, sum_squares, sample_count   | one result per fitted-channel sample
//
// A sample passes through these steps after its transfer: offset update, gain multiply, square,
// and accumulate into the result register. The next sample is not taken before the accumulate
// step, so samples do not overlap, as the single shared multiplier is used twice per sample.
// A sample of an absent channel is dropped in the offset step with no result. Reset returns
// all channel offsets to midscale, clears sums and counts, and sets both gains to their
// default. A stalled result holds the block in the accumulate step.
module dc_blocked_power_meter #(
  parameter int CHANNELS = dcpm_pkg::DEF_CHANNELS,
  parameter int DC_SHIFT = dcpm_pkg::DEF_DC_SHIFT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dcpm_cfg_if.sink          cfg_i,
  dcpm_in_if.sink           in_i,
  dcpm_out_if.source        res_o
);
  import dcpm_pkg::*;

  // Offset stays below 4096 << DC_SHIFT
  localparam int OFF_W = SAMPLE_W + DC_SHIFT;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [OFF_W-1:0] OFF_RESET = OFF_W'(MIDSCALE) << DC_SHIFT;

  ctrl_t ctrl;

  // Configuration registers
  logic [SCALE_W-1:0] vscale_q, cscale_q;

  // Captured sample
  logic [CH_W-1:0]     ch_q;
  logic [SAMPLE_W-1:0] sample_q;

  // Per-channel state
  logic [OFF_W-1:0]   offset_q [CHANNELS];
  logic [SUM_W-1:0]   sum_q    [CHANNELS];
  logic [COUNT_W-1:0] cnt_q    [CHANNELS];

  // Datapath
  logic [IDX_W-1:0]          idx;
  logic                      ch_ok;
  logic [OFF_W-1:0]          off_rd;
  logic signed [DIFF_W-1:0]  diff_d, diff_q;
  logic [OFF_W-1:0]          off_new;
  logic [SCALE_W-1:0]        gain;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  scaled;
  logic signed [VALUE_W-1:0] val_d, val_q;
  logic [SQ_W-1:0]           sq;
  logic [SUM_W:0]            sum_ext;
  logic [SUM_W-1:0]          sum_new;
  logic [COUNT_W-1:0]        cnt_new;

  // Result register
  logic                      out_valid_q, out_valid_d;
  logic                      out_free;
  logic [CH_W-1:0]           out_ch_q;
  logic signed [VALUE_W-1:0] out_val_q;
  logic [SUM_W-1:0]          out_sum_q;
  logic [COUNT_W-1:0]        out_cnt_q;

  // ---------------------------------------------------------------------------
  // Configuration: always ready, writes beyond the list are dropped
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vscale_q <= SCALE_RESET;
      cscale_q <= SCALE_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_VOLTAGE_SCALE) begin
        vscale_q <= cfg_i.data;
      end
      if (cfg_i.index == REG_CURRENT_SCALE) begin
        cscale_q <= cfg_i.data;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and shared multiplier
  // ---------------------------------------------------------------------------
  assign out_free   = !out_valid_q || res_o.ready;
  assign in_i.ready = ctrl.in_ready;

  dcpm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .ch_ok_i    (ch_ok),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  dcpm_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .op_i   (ctrl.mul_op),
    .diff_i (diff_q),
    .gain_i (gain),
    .val_i  (val_d),
    .prod_o (prod)
  );

  // Capture the sample on its transfer
  always_ff @(posedge clk_i) begin
    if (ctrl.capture) begin
      ch_q     <= in_i.channel;
      sample_q <= in_i.sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    idx    = IDX_W'(ch_q);
    ch_ok  = 32'(ch_q) < CHANNELS;
    off_rd = offset_q[idx];
    // subtract the offset estimate, floored to sample scale
    diff_d = $signed(DIFF_W'(sample_q)) - $signed(DIFF_W'(off_rd[OFF_W-1:DC_SHIFT]));
    off_new = off_rd + OFF_W'(diff_d);
    gain   = (ch_q == '0) ? vscale_q : cscale_q;

    // floor shift of the scaled product, clamp to the value range
    scaled = prod >>> GAIN_SHIFT;
    if (scaled > VAL_MAX) begin
      val_d = VALUE_W'(VAL_MAX);
    end else if (scaled < VAL_MIN) begin
      val_d = VALUE_W'(VAL_MIN);
    end else begin
      val_d = VALUE_W'(scaled);
    end

    // square is non-negative and below 2^27
    sq      = prod[SQ_W-1:0];
    sum_ext = {1'b0, sum_q[idx]} + (SUM_W + 1)'(sq);
    sum_new = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    cnt_new = cnt_q[idx] + COUNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.diff_en) begin
      diff_q <= diff_d;
    end
    if (ctrl.val_en) begin
      val_q <= val_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        offset_q[i] <= OFF_RESET;
        sum_q[i]    <= '0;
        cnt_q[i]    <= '0;
      end
    end else begin
      if (ctrl.diff_en) begin
        offset_q[idx] <= off_new;
      end
      if (ctrl.commit) begin
        sum_q[idx] <= sum_new;
        cnt_q[idx] <= cnt_new;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load on commit, drop on transfer
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.commit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      out_ch_q  <= ch_q;
      out_val_q <= val_q;
      out_sum_q <= sum_new;
      out_cnt_q <= cnt_new;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.channel_out  = out_ch_q;
  assign res_o.value        = out_val_q;
  assign res_o.sum_squares  = out_sum_q;
  assign res_o.sample_count = out_cnt_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |-> out_free)
    else $error("result committed over a pending result");

  a_mul_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.mul_en |-> !ctrl.in_ready)
    else $error("sample taken while the multiplier is busy");

  a_diff_then_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.diff_en |=> ctrl.mul_en && ctrl.mul_op == MUL_SCALE)
    else $error("offset step not followed by gain multiply");

  a_sum_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |-> sum_new >= sum_q[idx])
    else $error("sum of squares decreased");

endmodule
